@@ design/mvrn_pkg.sv @@
`default_nettype none

package mvrn_pkg;

    // vector store depth and addressing
    localparam int MAX_COLS   = 64;
    localparam int ADDR_W     = $clog2(MAX_COLS);
    localparam int COL_W      = 6;
    localparam int COL_EXT_W  = 13;

    // command queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    // square root unit, one result bit per step
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_MATRIX = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COL_W-1:0]   col_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] target_value;
        logic               row_end;
        logic               matrix_end;
    } t_in;

    typedef struct packed {
        logic [31:0] norm_value;
        logic        saturated;
    } t_out;

    // classified command held in the queue
    typedef struct packed {
        logic               is_load;
        logic               in_range;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] elem;
        logic signed [31:0] target;
        logic               close_row;
        logic               mat_end;
    } t_cmd;

    // hand-off to the square root unit
    typedef struct packed {
        logic [63:0] sum;
        logic        sat;
    } t_sq_req;

    typedef struct packed {
        logic signed [63:0] val;
        logic               ovf;
    } t_sadd;

    function automatic t_sadd sat_add_s64(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
        t_sadd       res;
        logic [63:0] s;
        s       = a + b;
        res.ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (res.ovf) begin
            res.val = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            res.val = s;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/matvec_residual_norm_top.sv @@
// residual norm ||A*x - b|| of signed Q16.16 data, streamed one beat at a time
//
// input channel (i_in_valid / o_in_ready / i_in_data): a load beat writes one
// element of x into the vector store; a matrix beat multiplies one entry of A
// by the stored x element of its column and adds it to the row accumulator.
// row_end closes a row (subtract b_i, add the squared residual to the sum);
// matrix_end also closes the row and starts the final square root.
// output channel (o_out_valid / i_out_ready / o_out_data): one beat per
// matrix_end, carrying the Q16.16 norm and a sticky saturation flag.
//
// throughput: one input beat per cycle while the queue has room; the front
// queue decouples input from the back pipeline. a matrix_end beat reaches
// its result through the queue, 6 pipeline stages, root unit load, 32
// two-bit root steps and the output register. a second matrix_end reaching the
// end of the pipeline while the root unit is busy holds the back end until
// the unit frees up.
// a result waiting on a stalled receiver sits in the root unit's output
// register; the unit can start the next root meanwhile, then holds.
// reset clears queue, pipeline valids, accumulators and flags; the vector
// store is not cleared and reads undefined until loaded.
`default_nettype none

module matvec_residual_norm_top
    import mvrn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // item input
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    // result output
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // queue head toward the back end
    logic    w_head_valid;
    t_cmd    w_head;
    logic    w_pop;
    // back end to root unit
    logic    w_sq_start;
    t_sq_req w_sq_req;
    logic    w_sq_ready;

    // front: classify each beat and queue it
    mvrn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back: vector store, multiply-accumulate, residual, square, sum
    mvrn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_sq_start   (w_sq_start),
        .o_sq_req     (w_sq_req),
        .i_sq_ready   (w_sq_ready)
    );

    // bit-serial square root with output register
    mvrn_sqrt u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_sq_start),
        .i_req       (w_sq_req),
        .o_ready     (w_sq_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ design/mvrn_front.sv @@
`default_nettype none

module mvrn_front
    import mvrn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_head_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QPTR_W:0]      r_count;
    t_cmd                 r_q [QDEPTH];
    t_cmd                 w_cmd;
    logic                 w_push;
    logic [COL_EXT_W-1:0] w_col_ext;
    logic [QPTR_W:0]      n_count;

    // classify the incoming beat
    always_comb begin
        w_col_ext       = COL_EXT_W'(i_in_data.col_index);
        w_cmd.is_load   = (i_in_data.req_type == REQ_LOAD);
        w_cmd.in_range  = (w_col_ext < COL_EXT_W'(MAX_COLS));
        w_cmd.addr      = w_col_ext[ADDR_W-1:0];
        w_cmd.elem      = i_in_data.elem_value;
        w_cmd.target    = i_in_data.target_value;
        w_cmd.close_row = i_in_data.row_end | i_in_data.matrix_end;
        w_cmd.mat_end   = i_in_data.matrix_end;
    end

    assign o_in_ready   = (r_count != (QPTR_W+1)'(QDEPTH));
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (!w_push && i_pop) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/mvrn_back.sv @@
`default_nettype none

module mvrn_back
    import mvrn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_head_valid,
    input  t_cmd    i_head,
    output logic    o_pop,
    output logic    o_sq_start,
    output t_sq_req o_sq_req,
    input  logic    i_sq_ready
);

    logic [31:0] r_vec_mem [MAX_COLS];

    // stage 1: store read
    logic               r_s1_valid;
    logic               r_s1_in_range;
    logic               r_s1_close;
    logic               r_s1_end;
    logic signed [31:0] r_s1_elem;
    logic signed [31:0] r_s1_target;
    logic signed [31:0] r_s1_vec;
    // stage 2: product
    logic               r_s2_valid;
    logic               r_s2_close;
    logic               r_s2_end;
    logic signed [31:0] r_s2_target;
    logic signed [63:0] r_s2_prod;
    // row accumulator
    logic signed [63:0] r_acc;
    logic               r_row_sat;
    // stage 3: closed row sum
    logic               r_s3_valid;
    logic               r_s3_end;
    logic signed [63:0] r_s3_acc;
    logic signed [31:0] r_s3_target;
    logic               r_s3_sat;
    // stage 4: residual
    logic               r_s4_valid;
    logic               r_s4_end;
    logic signed [63:0] r_s4_resid;
    logic               r_s4_sat;
    // stage 5: partial squares
    logic               r_s5_valid;
    logic               r_s5_end;
    logic               r_s5_big;
    logic [31:0]        r_s5_hh;
    logic [47:0]        r_s5_hl;
    logic [63:0]        r_s5_ll;
    logic               r_s5_sat;
    // stage 6: square
    logic               r_s6_valid;
    logic               r_s6_end;
    logic [63:0]        r_s6_sq;
    logic               r_s6_sat;
    // running sum of squares
    logic [63:0]        r_sq_sum;
    logic               r_mat_sat;

    logic               w_adv;
    logic signed [63:0] w_mul;
    logic signed [63:0] w_prod;
    t_sadd              w_acc_add;
    logic signed [63:0] w_tgt64;
    logic signed [63:0] w_neg_tgt;
    t_sadd              w_res;
    logic [63:0]        w_mag;
    logic [31:0]        w_hi;
    logic [31:0]        w_lo;
    logic [65:0]        w_total;
    logic               w_sq_ovf;
    logic [63:0]        w_sq;
    logic [64:0]        w_sum65;
    logic [63:0]        w_sum;
    logic               w_sat_all;
    logic signed [63:0] n_acc;
    logic               n_row_sat;
    logic [63:0]        n_sq_sum;
    logic               n_mat_sat;

    // whole pipeline waits while a matrix end cannot enter the root unit
    assign w_adv = !(r_s6_valid && r_s6_end && !i_sq_ready);
    assign o_pop = w_adv && i_head_valid;

    always_comb begin
        w_mul     = r_s1_elem * r_s1_vec;
        w_prod    = r_s1_in_range ? w_mul : '0;

        w_acc_add = sat_add_s64(r_acc, r_s2_prod);

        w_tgt64   = {{16{r_s3_target[31]}}, r_s3_target, 16'b0};
        w_neg_tgt = 64'sd0 - w_tgt64;
        w_res     = sat_add_s64(r_s3_acc, w_neg_tgt);

        w_mag     = r_s4_resid[63] ? (64'd0 - r_s4_resid) : r_s4_resid;
        w_hi      = w_mag[63:32];
        w_lo      = w_mag[31:0];

        w_total   = {2'b00, r_s5_hh, 32'b0} + {17'b0, r_s5_hl, 1'b0}
                  + {34'b0, r_s5_ll[63:32]};
        w_sq_ovf  = r_s5_big || (w_total[65:64] != 2'b00);
        w_sq      = w_sq_ovf ? {64{1'b1}} : w_total[63:0];

        w_sum65   = {1'b0, r_sq_sum} + {1'b0, r_s6_sq};
        w_sum     = w_sum65[64] ? {64{1'b1}} : w_sum65[63:0];
        w_sat_all = r_mat_sat | r_s6_sat | w_sum65[64];
    end

    always_comb begin
        n_acc     = r_acc;
        n_row_sat = r_row_sat;
        if (r_s2_valid) begin
            if (r_s2_close) begin
                n_acc     = '0;
                n_row_sat = 1'b0;
            end else begin
                n_acc     = w_acc_add.val;
                n_row_sat = r_row_sat | w_acc_add.ovf;
            end
        end
        n_sq_sum  = r_sq_sum;
        n_mat_sat = r_mat_sat;
        if (r_s6_valid) begin
            if (r_s6_end) begin
                n_sq_sum  = '0;
                n_mat_sat = 1'b0;
            end else begin
                n_sq_sum  = w_sum;
                n_mat_sat = w_sat_all;
            end
        end
    end

    assign o_sq_start   = r_s6_valid && r_s6_end && i_sq_ready;
    assign o_sq_req.sum = w_sum;
    assign o_sq_req.sat = w_sat_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_acc      <= '0;
            r_row_sat  <= 1'b0;
            r_sq_sum   <= '0;
            r_mat_sat  <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= o_pop && !i_head.is_load;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_close;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_acc      <= n_acc;
            r_row_sat  <= n_row_sat;
            r_sq_sum   <= n_sq_sum;
            r_mat_sat  <= n_mat_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (o_pop && i_head.is_load && i_head.in_range) begin
                r_vec_mem[i_head.addr] <= i_head.elem;
            end
            r_s1_vec <= r_vec_mem[i_head.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_in_range <= i_head.in_range;
            r_s1_close    <= i_head.close_row;
            r_s1_end      <= i_head.mat_end;
            r_s1_elem     <= i_head.elem;
            r_s1_target   <= i_head.target;

            r_s2_close    <= r_s1_close;
            r_s2_end      <= r_s1_end;
            r_s2_target   <= r_s1_target;
            r_s2_prod     <= w_prod;

            r_s3_end      <= r_s2_end;
            r_s3_acc      <= w_acc_add.val;
            r_s3_target   <= r_s2_target;
            r_s3_sat      <= r_row_sat | w_acc_add.ovf;

            r_s4_end      <= r_s3_end;
            r_s4_resid    <= w_res.val;
            r_s4_sat      <= r_s3_sat | w_res.ovf;

            r_s5_end      <= r_s4_end;
            r_s5_big      <= (w_hi[31:16] != 16'd0);
            r_s5_hh       <= w_hi[15:0] * w_hi[15:0];
            r_s5_hl       <= w_hi[15:0] * w_lo;
            r_s5_ll       <= w_lo * w_lo;
            r_s5_sat      <= r_s4_sat;

            r_s6_end      <= r_s5_end;
            r_s6_sq       <= w_sq;
            r_s6_sat      <= r_s5_sat | w_sq_ovf;
        end
    end

    // a stalled matrix end stays in the last stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_s6_valid && r_s6_end))
        else $error("matrix end left last stage during stall");

    // a matrix end leaves a clean sum behind
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s6_valid && r_s6_end) |=> (r_sq_sum == '0 && !r_mat_sat))
        else $error("square sum not cleared after matrix end");

    // closing a row restarts the accumulator
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_valid && r_s2_close) |=> (r_acc == '0 && !r_row_sat))
        else $error("row accumulator not cleared after row end");

endmodule

`default_nettype wire

@@ design/mvrn_sqrt.sv @@
`default_nettype none

module mvrn_sqrt
    import mvrn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_sq_req i_req,
    output logic    o_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]            r_state;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic [63:0]           r_x;
    logic [32:0]           r_rem;
    logic [31:0]           r_root;
    logic                  r_sat;
    logic                  r_out_valid;
    t_out                  r_out;

    logic [34:0] w_rem_sh;
    logic [34:0] w_trial;
    logic [34:0] w_diff;
    logic        w_ge;
    logic [32:0] n_rem;
    logic [31:0] n_root;
    logic        w_slot_free;

    // restoring square root, two radicand bits per step
    always_comb begin
        w_rem_sh = {r_rem, r_x[63:62]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_diff   = w_rem_sh - w_trial;
        w_ge     = (w_rem_sh >= w_trial);
        n_rem    = w_ge ? w_diff[32:0] : w_rem_sh[32:0];
        n_root   = {r_root[30:0], w_ge};
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_HOLD && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RUN;
                        r_cnt   <= SQRT_CNT_W'(SQRT_STEPS - 1);
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt - SQRT_CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_x    <= i_req.sum;
            r_rem  <= '0;
            r_root <= '0;
            r_sat  <= i_req.sat;
        end else if (r_state == S_RUN) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
        if (r_state == S_HOLD && w_slot_free) begin
            r_out.norm_value <= r_root;
            r_out.saturated  <= r_sat;
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

// self-checking bench for matvec_residual_norm_top
// - a short table of directed beats (norms typed in where obvious), then
//   random matrices, vector reloads and broken sequences
// - every accepted input beat runs through a bit-accurate residual/norm
//   predictor; results are compared in order against the expected queue
module testbench;
    import mvrn_pkg::*;

    localparam int N_RANDOM       = 550;
    localparam int WATCHDOG_LIMIT = 2000;
    // root unit latency plus a possible back-end hold, with margin
    localparam int DRAIN_CYCLES   = 100;

    // directed table row: beat plus an optional typed-in result
    typedef struct {
        t_in  beat;
        bit   typed;
        t_out want;
    } t_dir_row;

    logic i_clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // predictor state: vector store, row accumulator, sum of squares, sticky flag
    logic signed [31:0] vec_x [MAX_COLS];
    bit                 x_loaded [MAX_COLS];
    logic signed [63:0] row_acc;
    logic [63:0]        sq_sum;
    bit                 sat_seen;

    t_out     norm_q [$];
    t_dir_row dir_tab [$];
    int       errors     = 0;
    int       beats_sent = 0;
    int       idle_cnt   = 0;
    bit       calm       = 1'b0;

    matvec_residual_norm_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // signed 64-bit add, clamped on overflow
    function automatic logic signed [63:0] add_clamp_s(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat_seen = 1'b1;
            return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    // unsigned 64-bit add, clamped at all ones
    function automatic logic [63:0] add_clamp_u(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (s < a) begin
            sat_seen = 1'b1;
            return '1;
        end
        return s;
    endfunction

    // floor(r*r / 2^32) of a signed q32.32 residual, clamped to 64 bits
    function automatic logic [63:0] square_resid(input logic signed [63:0] r);
        logic [63:0] m, hi, lo, acc;
        m  = r[63] ? (64'd0 - r) : r;
        hi = {32'd0, m[63:32]};
        lo = {32'd0, m[31:0]};
        if (hi >= 64'h1_0000) begin
            sat_seen = 1'b1;
            return '1;
        end
        acc = (hi * hi) << 32;
        acc = add_clamp_u(acc, 64'd2 * hi * lo);
        acc = add_clamp_u(acc, (lo * lo) >> 32);
        return acc;
    endfunction

    // integer square root, digit by digit
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r, probe;
        r     = '0;
        probe = 64'd1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= r + probe) begin
                x = x - (r + probe);
                r = (r >> 1) + probe;
            end else begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    // advance the predictor by one beat; returns 1 when a norm comes out
    function automatic bit residual_step(input t_in b, output t_out res);
        logic signed [63:0] a64, x64, t64;
        res = '0;
        if (b.req_type == REQ_LOAD) begin
            vec_x[b.col_index]    = b.elem_value;
            x_loaded[b.col_index] = 1'b1;
            return 1'b0;
        end
        a64     = $signed(b.elem_value);
        x64     = $signed(vec_x[b.col_index]);
        row_acc = add_clamp_s(row_acc, a64 * x64);
        if (b.row_end || b.matrix_end) begin
            t64     = $signed(b.target_value);
            t64     = t64 <<< 16;
            sq_sum  = add_clamp_u(sq_sum, square_resid(add_clamp_s(row_acc, -t64)));
            row_acc = '0;
        end
        if (!b.matrix_end) return 1'b0;
        res.norm_value = 32'(root_floor(sq_sum));
        res.saturated  = sat_seen;
        row_acc  = '0;
        sq_sum   = '0;
        sat_seen = 1'b0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_dir_row mk_row(input logic kind, input int col,
                                        input logic [31:0] elem, input logic [31:0] tgt,
                                        input int re, input int me, input int typed,
                                        input logic [31:0] norm, input int sat);
        t_dir_row row;
        row.beat.req_type     = kind;
        row.beat.col_index    = col[COL_W-1:0];
        row.beat.elem_value   = elem;
        row.beat.target_value = tgt;
        row.beat.row_end      = re[0];
        row.beat.matrix_end   = me[0];
        row.typed             = typed[0];
        row.want.norm_value   = norm;
        row.want.saturated    = sat[0];
        return row;
    endfunction

    // append one row to the directed table
    function automatic void tab_add(input t_dir_row row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    // mostly small q16.16 values so norms stay meaningful, some full range
    function automatic logic [31:0] draw_fixed();
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // any column that already holds a loaded element
    function automatic logic [COL_W-1:0] pick_col();
        int c, k;
        c = $urandom_range(0, MAX_COLS - 1);
        for (k = 0; k < MAX_COLS; k++) begin
            if (x_loaded[(c + k) % MAX_COLS]) return COL_W'((c + k) % MAX_COLS);
        end
        return '0;
    endfunction

    // vector load with junk in the fields the block ignores
    function automatic t_in rand_load();
        t_in b;
        b.req_type     = REQ_LOAD;
        b.col_index    = COL_W'($urandom_range(0, MAX_COLS - 1));
        b.elem_value   = draw_fixed();
        b.target_value = $urandom();
        b.row_end      = 1'($urandom_range(0, 1));
        b.matrix_end   = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic t_in rand_entry(input logic re, input logic me);
        t_in b;
        b.req_type     = REQ_MATRIX;
        b.col_index    = pick_col();
        b.elem_value   = draw_fixed();
        b.target_value = draw_fixed();
        b.row_end      = re;
        b.matrix_end   = me;
        return b;
    endfunction

    // offer one beat after a random gap, hold it until accepted, then predict
    task automatic push_beat(input t_in b, input bit use_typed, input t_out typed_res);
        int   gap;
        t_out pred;
        bit   got;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        beats_sent++;
        got = residual_step(b, pred);
        if (got) norm_q.insert(norm_q.size(), use_typed ? typed_res : pred);
    endtask

    // sender holds off until every outstanding norm has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (norm_q.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls, in-order compare
    // ---------------------------------------------------------------
    initial begin
        int   stall;
        t_out want;
        while (rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (norm_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: norm %h sat %b",
                         $time, o_out_data.norm_value, o_out_data.saturated);
                errors++;
            end else begin
                want = norm_q.pop_front();
                if (o_out_data.norm_value !== want.norm_value) begin
                    $display("%0t: norm_value expected %h actual %h",
                             $time, want.norm_value, o_out_data.norm_value);
                    errors++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, o_out_data.saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without a beat on either channel
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && out_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, norm_q.size());
            $display("FAIL matvec_residual_norm_top");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int   n_rows, row_len, r, e, k;
        bit   last_r, last_e;
        t_in  b;
        t_out none;
        none     = '0;
        row_acc  = '0;
        sq_sum   = '0;
        sat_seen = 1'b0;
        for (k = 0; k < MAX_COLS; k++) begin
            vec_x[k]    = '0;
            x_loaded[k] = 1'b0;
        end

        // vector loads: 1.0, both extremes, top index, -1.0
        tab_add(mk_row(REQ_LOAD, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_LOAD, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_LOAD, 2, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_LOAD, 63, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_LOAD, 5, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0));
        // load carrying both marks and a target: must not close anything
        tab_add(mk_row(REQ_LOAD, 3, 32'h0, 32'h7FFF_FFFF, 1, 1, 0, 0, 0));
        // rows 3.0 and 4.0 against zero targets: norm 5.0
        tab_add(mk_row(REQ_MATRIX, 0, 32'h0003_0000, 0, 1, 0, 0, 0, 0));
        tab_add(mk_row(REQ_MATRIX, 63, 32'h0004_0000, 0, 1, 1, 1, 32'h0005_0000, 0));
        // matrix end without row end still closes the row: |2 - 5| = 3.0
        tab_add(mk_row(REQ_MATRIX, 0, 32'h0002_0000, 32'h0005_0000, 0, 1,
                       1, 32'h0003_0000, 0));
        // two 2^62 products overflow the accumulator, full-scale norm
        tab_add(mk_row(REQ_MATRIX, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_MATRIX, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_MATRIX, 3, 32'h0001_0000, 0, 1, 1, 1, 32'hFFFF_FFFF, 1));
        // accumulators and flag cleared: zero product, zero target
        tab_add(mk_row(REQ_MATRIX, 3, 32'h7FFF_FFFF, 0, 1, 1, 1, 32'h0, 0));
        // extreme entries and targets, predictor checked
        tab_add(mk_row(REQ_MATRIX, 2, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0, 0));
        tab_add(mk_row(REQ_MATRIX, 5, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 0, 0, 0));
        // two large negative products bring the accumulator close to its negative limit
        tab_add(mk_row(REQ_MATRIX, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
        tab_add(mk_row(REQ_MATRIX, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0, 0, 0));

        // synchronous reset, released before the directed beats
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) push_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

        // pause the sender until the directed norms are all back
        drain_results();

        while (beats_sent < dir_tab.size() + N_RANDOM) begin
            // occasional stretch with no idling on either side
            calm = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // burst of vector reloads
                    repeat ($urandom_range(1, 4)) push_beat(rand_load(), 1'b0, none);
                end
                2: begin
                    // broken sequence: stray marks, sometimes a lone matrix end
                    b = rand_entry(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                    push_beat(b, 1'b0, none);
                end
                default: begin
                    // well-formed matrix with random content
                    n_rows = $urandom_range(1, 4);
                    for (r = 0; r < n_rows; r++) begin
                        row_len = $urandom_range(1, 6);
                        for (e = 0; e < row_len; e++) begin
                            if ($urandom_range(0, 15) == 0) begin
                                push_beat(rand_load(), 1'b0, none);
                            end
                            last_e = (e == row_len - 1);
                            last_r = (r == n_rows - 1);
                            // last row sometimes closed by matrix end alone
                            b = rand_entry(last_e && !(last_r && $urandom_range(0, 3) == 0),
                                           last_e && last_r);
                            push_beat(b, 1'b0, none);
                        end
                    end
                end
            endcase
            if ($urandom_range(0, 19) == 0) drain_results();
        end
        calm = 1'b0;

        // wait out the last norms, then a few more cycles for stray beats
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS matvec_residual_norm_top");
        end else begin
            $display("FAIL matvec_residual_norm_top");
        end
        $finish;
    end

endmodule
